// ===== rtl/core/gbn_pkg.sv =====
// Shared types and constants of the go-back-n sender.
`timescale 1ns / 1ps

package gbn_pkg;

	localparam int DEF_WINDOW_DEPTH = 16;
	localparam int DEF_SEQ_BITS     = 8;
	localparam int DEF_PAYLOAD_BITS = 64;
	localparam int DEF_TIMER_BITS   = 16;

	localparam int MAX_WINDOW     = 15;
	localparam int CNT_BITS       = 4;
	localparam int WIN_BITS       = 4;
	localparam int TMO_BITS       = 16;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(15);
	localparam logic [TMO_BITS-1:0] TMO_RESET = TMO_BITS'(1000);

	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW  = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_TIMEOUT = CFG_INDEX_BITS'(1);

	typedef enum logic [1:0] {
		KIND_SEND = 2'd0,
		KIND_ACK  = 2'd1,
		KIND_TICK = 2'd2,
		KIND_NONE = 2'd3
	} in_kind_t;

	typedef enum logic [1:0] {
		RES_SENT    = 2'd0,
		RES_REFUSED = 2'd1,
		RES_ACK     = 2'd2,
		RES_RESENT  = 2'd3
	} res_kind_t;

endpackage

// ===== rtl/core/gbn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module gbn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/gbn_mod.sv =====
// Reduction of a sequence number modulo the store depth by reciprocal multiplication.
`timescale 1ns / 1ps

module gbn_mod #(
	parameter int SEQ_BITS = 8,
	parameter int DEPTH    = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [SEQ_BITS-1:0]      value,
	output logic                     done,
	output logic [$clog2(DEPTH)-1:0] rem
);

	localparam int     AW    = $clog2(DEPTH);
	localparam int     SH    = SEQ_BITS + AW;
	localparam int     MW    = SEQ_BITS + 2;
	localparam int     PW    = SH + SEQ_BITS;
	localparam int     QW    = SEQ_BITS + AW;
	localparam longint RECIP = ((longint'(1) << SH) + longint'(DEPTH) - 1) / longint'(DEPTH);
	localparam logic [MW-1:0] RECIP_C = MW'(RECIP);
	localparam logic [QW-1:0] DEPTH_C = QW'(DEPTH);

	logic                vld_s1;
	logic [PW-1:0]       prod_s1;
	logic [SEQ_BITS-1:0] val_s1;
	logic                done_q;
	logic [AW-1:0]       rem_q;
	logic [SEQ_BITS-1:0] quot;
	logic [QW-1:0]       rem_full;

	// rounded-up reciprocal gives the exact quotient for every SEQ_BITS-wide value
	always_comb begin
		quot     = prod_s1[SH +: SEQ_BITS];
		rem_full = QW'(val_s1) - QW'(quot) * DEPTH_C;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= PW'(value) * PW'(RECIP_C);
			val_s1  <= value;
		end
		if (vld_s1) begin
			rem_q <= rem_full[AW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/core/go_back_n_sender.sv =====
// Go-back-n sender top level: window control, retransmit timer and resend sequencer.
//
//  channel | dir | handshake         | content
//  s_      | in  | s_tvalid/s_tready | tuser kind; tdata payload, ack_num, ack_checksum_ok
//  m_      | out | m_tvalid/m_tready | tuser result_kind; tdata result fields; tlast last
//  cfg_    | in  | cfg_valid/ready   | cfg_index register, cfg_data value
//
// A send, ack or tick is taken while the block is idle and the output register is empty or
// drains. A timer expiry reduces the window base to a store address, then reads up to 15
// packets through the store's read port, oldest first, each once the output register is free.
// Reset clears the window, the timer and the output register; the store needs no clearing.
// A stall on m_ holds the output word and blocks s_ until the word is taken.
`timescale 1ns / 1ps

module go_back_n_sender
	import gbn_pkg::*;
#(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	parameter int SEQ_BITS     = DEF_SEQ_BITS,
	parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
	parameter int TIMER_BITS   = DEF_TIMER_BITS,
	localparam int IN_F  = PAYLOAD_BITS + SEQ_BITS + 1,
	localparam int IN_W  = ((IN_F + 7) / 8) * 8,
	localparam int OUT_F = 3 * SEQ_BITS + PAYLOAD_BITS + 1,
	localparam int OUT_W = ((OUT_F + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_W-1:0]           s_tdata,  // payload, ack_num, ack_checksum_ok
	input  logic [1:0]                s_tuser,  // kind
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_W-1:0]          m_tdata,  // seq_num, packet_payload, window_base,
	                                            // next_sequence, ack_accepted
	output logic [1:0]                m_tuser,  // result_kind
	output logic                      m_tlast,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int AW    = $clog2(WINDOW_DEPTH);
	localparam int CMP_W = SEQ_BITS + 8;
	localparam int CW    = (TIMER_BITS > TMO_BITS) ? TIMER_BITS : TMO_BITS;
	localparam logic [SEQ_BITS-1:0]   SEQ_MAX = {SEQ_BITS{1'b1}};
	localparam logic [TIMER_BITS-1:0] TMR_MAX = {TIMER_BITS{1'b1}};
	localparam logic [AW-1:0]         ADDR_TOP = AW'(WINDOW_DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOD,
		ST_RETX
	} state_t;

	// store address of the sequence number after s, given the address of s
	function automatic logic [AW-1:0] addr_step(input logic [AW-1:0] a,
		input logic [SEQ_BITS-1:0] s);
		logic [AW-1:0] r;
		if (s == SEQ_MAX || a == ADDR_TOP) begin
			r = '0;
		end else begin
			r = a + 1'b1;
		end
		return r;
	endfunction

	state_t                  state_q;
	logic [SEQ_BITS-1:0]     base_q;
	logic [SEQ_BITS-1:0]     next_q;
	logic [AW-1:0]           next_addr_q;
	logic [TIMER_BITS-1:0]   tmr_cnt_q;
	logic                    tmr_run_q;
	logic [WIN_BITS-1:0]     win_q;
	logic [TMO_BITS-1:0]     tmo_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic [CNT_BITS-1:0]     last_idx_q;
	logic [SEQ_BITS-1:0]     seq_q;
	logic [AW-1:0]           rd_addr_q;

	logic                    m_tvalid_q;
	res_kind_t               res_kind_q;
	logic [SEQ_BITS-1:0]     o_seq_q;
	logic [PAYLOAD_BITS-1:0] o_pay_q;
	logic [SEQ_BITS-1:0]     o_base_q;
	logic [SEQ_BITS-1:0]     o_next_q;
	logic                    o_acc_q;
	logic                    o_last_q;

	logic                    slot_free;
	logic                    in_acc;
	in_kind_t                in_kind;
	logic [PAYLOAD_BITS-1:0] in_payload;
	logic [SEQ_BITS-1:0]     in_ack;
	logic                    in_ok;
	logic [SEQ_BITS-1:0]     outstanding;
	logic [SEQ_BITS-1:0]     n_sat;
	logic                    win_ok;
	logic                    ack_ok;
	logic [SEQ_BITS-1:0]     base_new;
	logic [CW-1:0]           tmo_ext;
	logic [TIMER_BITS-1:0]   limit;
	logic [TIMER_BITS-1:0]   cnt_inc;
	logic                    retx_emit;
	logic                    retx_last;
	logic                    out_load;

	logic                    ram_we;
	logic                    ram_re;
	logic [AW-1:0]           ram_raddr;
	logic [PAYLOAD_BITS-1:0] ram_rdata;
	logic                    mod_start;
	logic                    mod_done;
	logic [AW-1:0]           mod_rem;

	always_comb begin
		slot_free   = !m_tvalid_q || m_tready;
		s_tready    = (state_q == ST_IDLE) && slot_free;
		in_acc      = s_tvalid && s_tready;
		in_kind     = in_kind_t'(s_tuser);
		in_payload  = s_tdata[PAYLOAD_BITS-1:0];
		in_ack      = s_tdata[PAYLOAD_BITS +: SEQ_BITS];
		in_ok       = s_tdata[PAYLOAD_BITS + SEQ_BITS];
		outstanding = next_q - base_q;
		n_sat       = (CMP_W'(outstanding) > CMP_W'(MAX_WINDOW)) ?
		              SEQ_BITS'(MAX_WINDOW) : outstanding;
		win_ok      = (CMP_W'(outstanding) < CMP_W'(win_q)) &&
		              (CMP_W'(outstanding) < CMP_W'(WINDOW_DEPTH));
		ack_ok      = in_ok && (SEQ_BITS'(in_ack - base_q) < outstanding);
		base_new    = ack_ok ? SEQ_BITS'(in_ack + 1'b1) : base_q;

		tmo_ext = CW'(tmo_q);
		if (tmo_q == '0) begin
			limit = TIMER_BITS'(1);
		end else if (tmo_ext > CW'(TMR_MAX)) begin
			limit = TMR_MAX;
		end else begin
			limit = tmo_ext[TIMER_BITS-1:0];
		end
		cnt_inc = (tmr_cnt_q == TMR_MAX) ? tmr_cnt_q : tmr_cnt_q + 1'b1;

		retx_emit = (state_q == ST_RETX) && slot_free;
		retx_last = (cnt_q == last_idx_q);
		out_load  = (in_acc && ((in_kind == KIND_SEND) || (in_kind == KIND_ACK))) ||
		            retx_emit;

		ram_we    = in_acc && (in_kind == KIND_SEND) && win_ok;
		mod_start = in_acc && (in_kind == KIND_TICK) && tmr_run_q &&
		            (cnt_inc >= limit) && (outstanding != '0);
		ram_re    = ((state_q == ST_MOD) && mod_done) || (retx_emit && !retx_last);
		ram_raddr = (state_q == ST_MOD) ? mod_rem : rd_addr_q;
	end

	gbn_ram #(
		.WIDTH(PAYLOAD_BITS),
		.DEPTH(WINDOW_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (next_addr_q),
		.wdata (in_payload),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	gbn_mod #(
		.SEQ_BITS(SEQ_BITS),
		.DEPTH   (WINDOW_DEPTH)
	) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.value  (base_q),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			next_q      <= '0;
			next_addr_q <= '0;
			tmr_cnt_q   <= '0;
			tmr_run_q   <= 1'b0;
			win_q       <= WIN_RESET;
			tmo_q       <= TMO_RESET;
			cnt_q       <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW:  win_q <= cfg_data[WIN_BITS-1:0];
					REG_TIMEOUT: tmo_q <= cfg_data[TMO_BITS-1:0];
					default: ;
				endcase
			end

			// load a new word, or drop the old one once taken
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (slot_free) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_kind)
							KIND_SEND: begin
								o_last_q   <= 1'b1;
								o_acc_q    <= 1'b0;
								o_base_q   <= base_q;
								if (win_ok) begin
									res_kind_q  <= RES_SENT;
									o_seq_q     <= next_q;
									o_pay_q     <= in_payload;
									o_next_q    <= next_q + 1'b1;
									next_q      <= next_q + 1'b1;
									next_addr_q <= addr_step(next_addr_q, next_q);
									if (outstanding == '0) begin
										tmr_run_q <= 1'b1;
										tmr_cnt_q <= '0;
									end
								end else begin
									res_kind_q <= RES_REFUSED;
									o_seq_q    <= '0;
									o_pay_q    <= '0;
									o_next_q   <= next_q;
								end
							end
							KIND_ACK: begin
								o_last_q   <= 1'b1;
								res_kind_q <= RES_ACK;
								o_seq_q    <= '0;
								o_pay_q    <= '0;
								o_acc_q    <= ack_ok;
								o_base_q   <= base_new;
								o_next_q   <= next_q;
								base_q     <= base_new;
								tmr_cnt_q  <= '0;
								tmr_run_q  <= (next_q != base_new);
							end
							KIND_TICK: begin
								if (tmr_run_q) begin
									if (cnt_inc >= limit) begin
										tmr_cnt_q <= '0;
										if (outstanding != '0) begin
											last_idx_q <= CNT_BITS'(n_sat - 1'b1);
											cnt_q      <= '0;
											state_q    <= ST_MOD;
										end
									end else begin
										tmr_cnt_q <= cnt_inc;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_MOD: begin
					// first read goes out with the reduced base address
					if (mod_done) begin
						seq_q     <= base_q;
						rd_addr_q <= addr_step(mod_rem, base_q);
						state_q   <= ST_RETX;
					end
				end
				ST_RETX: begin
					if (retx_emit) begin
						res_kind_q <= RES_RESENT;
						o_seq_q    <= seq_q;
						o_pay_q    <= ram_rdata;
						o_base_q   <= base_q;
						o_next_q   <= next_q;
						o_acc_q    <= 1'b0;
						o_last_q   <= retx_last;
						if (retx_last) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q     <= cnt_q + 1'b1;
							seq_q     <= seq_q + 1'b1;
							rd_addr_q <= addr_step(rd_addr_q, seq_q + 1'b1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = res_kind_q;
	assign m_tlast   = o_last_q;
	assign m_tdata   = OUT_W'({o_acc_q, o_next_q, o_base_q, o_pay_q, o_seq_q});

	a_busy_holds_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> $stable(base_q) && $stable(next_q))
		else $error("window moved during retransmit");

	a_outstanding_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(SEQ_BITS'(next_q - base_q)) <= CMP_W'(MAX_WINDOW))
		else $error("too many packets outstanding");

	a_timer_needs_packets: assert property (@(posedge clk) disable iff (!arst_n)
		tmr_run_q |-> (next_q != base_q))
		else $error("timer running with nothing outstanding");

	a_resend_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RETX) && retx_emit && retx_last |=> (state_q == ST_IDLE) && m_tvalid)
		else $error("final resend word not presented");

endmodule

// ===== tb/sv/go_back_n_sender_tb.sv =====
// Self-checking bench for the go-back-n sender: window, acks, timer and resend bursts.
`timescale 1ns / 1ps

module go_back_n_sender_tb;
	import gbn_pkg::*;

	localparam int SEQ_W         = DEF_SEQ_BITS;
	localparam int PAY_W         = DEF_PAYLOAD_BITS;
	localparam int DEPTH         = DEF_WINDOW_DEPTH;
	localparam int IN_W          = ((PAY_W + SEQ_W + 1 + 7) / 8) * 8;
	localparam int OUT_W         = ((3 * SEQ_W + PAY_W + 1 + 7) / 8) * 8;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 200000;

	typedef struct {
		res_kind_t        kind;
		logic [SEQ_W-1:0] seq;
		logic [PAY_W-1:0] payload;
		logic [SEQ_W-1:0] base;
		logic [SEQ_W-1:0] next_seq;
		logic             accepted;
		logic             last;
	} arq_word_t;

	// Window state of the sender and the words it owes the output
	class arq_window;
		logic [PAY_W-1:0] store [DEPTH];
		logic [SEQ_W-1:0] base_seq;
		logic [SEQ_W-1:0] next_seq;
		logic [15:0]      timer_count;
		logic [15:0]      timeout;
		logic [3:0]       window;
		bit               timer_on;
		arq_word_t        pending_words [$];
		int failures, n_sent, n_refused, n_acks, n_acks_ok, n_resent;

		function new();
			base_seq    = '0;
			next_seq    = '0;
			timer_count = '0;
			timer_on    = 1'b0;
			window      = WIN_RESET;
			timeout     = TMO_RESET;
			failures    = 0;
			n_sent      = 0;
			n_refused   = 0;
			n_acks      = 0;
			n_acks_ok   = 0;
			n_resent    = 0;
		endfunction

		function logic [SEQ_W-1:0] outstanding();
			return next_seq - base_seq;
		endfunction

		function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
			if (idx == REG_WINDOW)
				window = value[WIN_BITS-1:0];
			else if (idx == REG_TIMEOUT)
				timeout = value[TMO_BITS-1:0];
		endfunction

		function void push_word(res_kind_t kind, logic [SEQ_W-1:0] seq,
		                        logic [PAY_W-1:0] payload, logic accepted, logic last);
			arq_word_t w;
			w.kind     = kind;
			w.seq      = seq;
			w.payload  = payload;
			w.base     = base_seq;
			w.next_seq = next_seq;
			w.accepted = accepted;
			w.last     = last;
			pending_words.push_back(w);
		endfunction

		function void take_item(in_kind_t kind, logic [PAY_W-1:0] payload,
		                        logic [SEQ_W-1:0] ack, logic ok);
			logic [SEQ_W-1:0] n;
			logic [SEQ_W-1:0] seq;
			logic [SEQ_W-1:0] ack_dist;
			logic [15:0]      limit;
			logic             accepted;
			n = outstanding();
			case (kind)
				KIND_SEND: begin
					// window is at most 15, below the store depth
					if (n < window) begin
						seq = next_seq;
						store[seq % DEPTH] = payload;
						if (n == 0) begin
							timer_on    = 1'b1;
							timer_count = '0;
						end
						next_seq = next_seq + 1'b1;
						push_word(RES_SENT, seq, payload, 1'b0, 1'b1);
						n_sent++;
					end else begin
						push_word(RES_REFUSED, '0, '0, 1'b0, 1'b1);
						n_refused++;
					end
				end
				KIND_ACK: begin
					ack_dist = ack - base_seq;
					accepted = ok && (ack_dist < n);
					if (accepted)
						base_seq = ack + 1'b1;
					timer_count = '0;
					timer_on    = (outstanding() != 0);
					push_word(RES_ACK, '0, '0, accepted, 1'b1);
					n_acks++;
					if (accepted)
						n_acks_ok++;
				end
				KIND_TICK: begin
					if (timer_on) begin
						limit = (timeout == 0) ? 16'd1 : timeout;
						if (timer_count != 16'hFFFF)
							timer_count = timer_count + 1'b1;
						// expiry: resend everything outstanding, oldest first
						if (timer_count >= limit) begin
							timer_count = '0;
							for (int i = 0; i < n; i++) begin
								seq = base_seq + SEQ_W'(i);
								push_word(RES_RESENT, seq, store[seq % DEPTH], 1'b0, i == n - 1);
								n_resent++;
							end
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void compare(string field, logic [PAY_W-1:0] want, logic [PAY_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				failures++;
			end
		endfunction

		function void check_word(arq_word_t got);
			arq_word_t want;
			if (pending_words.size() == 0) begin
				$error("result_kind: expected no word, got %0d", got.kind);
				failures++;
				return;
			end
			want = pending_words.pop_front();
			compare("result_kind", want.kind, got.kind);
			compare("seq_num", want.seq, got.seq);
			compare("packet_payload", want.payload, got.payload);
			compare("window_base", want.base, got.base);
			compare("next_sequence", want.next_seq, got.next_seq);
			compare("ack_accepted", want.accepted, got.accepted);
			compare("last", want.last, got.last);
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [IN_W-1:0]           s_tdata;   // payload, ack_num, ack_checksum_ok
	logic [1:0]                s_tuser;   // kind
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [OUT_W-1:0]          m_tdata;   // seq_num, packet_payload, window_base,
	                                      // next_sequence, ack_accepted
	logic [1:0]                m_tuser;   // result_kind
	logic                      m_tlast;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	arq_window tracker = new();
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	bit hold_req      = 1'b0;
	bit hold_done     = 1'b0;
	int hold_left     = 0;
	int cycle_count   = 0;

	go_back_n_sender DUT (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("go_back_n_sender test failed");
			$finish;
		end
	end

	// Output side: check each taken word, then pick next cycle's ready
	always @(posedge clk) begin : sink
		arq_word_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind     = res_kind_t'(m_tuser);
			got.seq      = m_tdata[SEQ_W-1:0];
			got.payload  = m_tdata[SEQ_W +: PAY_W];
			got.base     = m_tdata[SEQ_W+PAY_W +: SEQ_W];
			got.next_seq = m_tdata[2*SEQ_W+PAY_W +: SEQ_W];
			got.accepted = m_tdata[3*SEQ_W+PAY_W];
			got.last     = m_tlast;
			tracker.check_word(got);
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic put_item(input in_kind_t kind, input logic [PAY_W-1:0] payload = '0,
	                        input logic [SEQ_W-1:0] ack = '0, input logic ok = 1'b0);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {{(IN_W - PAY_W - SEQ_W - 1){1'b0}}, ok, ack, payload};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.take_item(kind, payload, ack, ok);
	endtask

	// Write both registers back to back; call only while the block is idle
	task automatic set_regs(input int window, input int timeout);
		cfg_valid <= 1'b1;
		cfg_index <= REG_WINDOW;
		cfg_data  <= CFG_DATA_BITS'(window);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_reg(REG_WINDOW, CFG_DATA_BITS'(window));
		cfg_index <= REG_TIMEOUT;
		cfg_data  <= CFG_DATA_BITS'(timeout);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tracker.set_reg(REG_TIMEOUT, CFG_DATA_BITS'(timeout));
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly sends, in-window acks and ticks; the rest bad acks and unknown kinds
	task automatic random_items(input int count);
		int               made;
		int               pick;
		logic [SEQ_W-1:0] n;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(99);
			n    = tracker.outstanding();
			if (pick < 45) begin
				put_item(KIND_SEND, {$urandom, $urandom}, SEQ_W'($urandom), 1'($urandom));
			end else if (pick < 65 && n != 0) begin
				put_item(KIND_ACK, {$urandom, $urandom},
				         tracker.base_seq + SEQ_W'($urandom_range(n - 1, 0)), 1'b1);
			end else if (pick < 85) begin
				put_item(KIND_TICK, {$urandom, $urandom}, SEQ_W'($urandom), 1'($urandom));
			end else if (pick < 96) begin
				put_item(KIND_ACK, {$urandom, $urandom}, SEQ_W'($urandom),
				         1'($urandom_range(3) == 0));
			end else begin
				put_item(KIND_NONE, {$urandom, $urandom}, SEQ_W'($urandom), 1'($urandom));
				continue;
			end
			made++;
		end
	endtask

	initial begin
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window zero refuses every send; timeout zero behaves as one
		set_regs(0, 0);
		put_item(KIND_SEND, '1, '1, 1'b1);
		put_item(KIND_NONE, '1, '1, 1'b1);
		put_item(KIND_TICK, '1, '1, 1'b1);
		put_item(KIND_ACK, '0, '0, 1'b1);
		drain();

		// upper data bits drop out of the window register: window of three
		set_regs(16'hFFF3, 0);
		put_item(KIND_SEND, '0, '1, 1'b1);
		put_item(KIND_SEND, '1, '0, 1'b0);
		put_item(KIND_SEND, 64'hA5A5_5A5A_0F0F_F0F0);
		put_item(KIND_SEND, 64'h0000_0000_0000_1234);
		put_item(KIND_TICK);
		put_item(KIND_ACK, '0, 8'd1, 1'b0);
		put_item(KIND_ACK, '0, 8'd200, 1'b1);
		put_item(KIND_ACK, '0, 8'd0, 1'b1);
		put_item(KIND_TICK);
		put_item(KIND_ACK, '0, 8'd2, 1'b1);
		put_item(KIND_TICK);
		put_item(KIND_ACK, '0, 8'd2, 1'b1);
		drain();

		set_regs(15, 1);
		put_item(KIND_SEND, 64'hFEDC_BA98_7654_3210);
		put_item(KIND_TICK);
		put_item(KIND_ACK, '0, 8'd3, 1'b1);
		drain();

		src_idle_pct  = 27;
		sink_idle_pct = 62;
		set_regs(15, 3);
		random_items(20);
		drain();

		src_idle_pct  = 62;
		sink_idle_pct = 27;
		set_regs(1, 2);
		random_items(20);
		drain();

		// long output stall while the input keeps offering words
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		set_regs(9, 65535);
		hold_req = 1'b1;
		random_items(20);
		drain();

		// full-window burst, then a resend of all fifteen
		set_regs(15, 1);
		put_item(KIND_ACK, '0, tracker.next_seq - 1'b1, 1'b1);
		repeat (15)
			put_item(KIND_SEND, {$urandom, $urandom}, SEQ_W'($urandom), 1'($urandom));
		put_item(KIND_TICK, {$urandom, $urandom}, SEQ_W'($urandom), 1'($urandom));
		put_item(KIND_ACK, {$urandom, $urandom}, tracker.next_seq - 1'b1, 1'b1);
		drain();

		$display("Run: %0d packets sent, %0d sends refused, %0d resent, %0d of %0d acks taken",
		         tracker.n_sent, tracker.n_refused, tracker.n_resent, tracker.n_acks_ok,
		         tracker.n_acks);
		$display("Windows 0..15, timeouts 0..65535, full-window resends and a long output stall");
		if (tracker.failures == 0)
			$display("go_back_n_sender test passed");
		else
			$display("go_back_n_sender test failed");
		$finish;
	end

endmodule
